@@ rtl/core/triangle_circumcenter_macros.svh @@
// assertion helpers for the circumcenter block
`ifndef TRIANGLE_CIRCUMCENTER_MACROS_SVH
`define TRIANGLE_CIRCUMCENTER_MACROS_SVH

// property that holds in every cycle outside reset
`define TCC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("tcc check failed");

// same-cycle implication
`define TCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tcc check failed");

`endif

@@ rtl/core/tcc_pkg.sv @@
`default_nettype none
package tcc_pkg;

  localparam int CoordW = 16;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int DW     = ProdW + 1;
  localparam int LenW   = ProdW;
  localparam int MagW   = ProdW;
  localparam int DenW   = MagW + 1;
  localparam int NumW   = LenW + DiffW;
  localparam int SatBit = 40;
  localparam int SumW   = SatBit + 2;
  localparam int OutW   = 32;
  localparam int ThrW   = 16;

  typedef struct packed {
    logic                bad;
    logic                neg_x;
    logic                neg_y;
    logic [CoordW-1:0]   ax;
    logic [CoordW-1:0]   ay;
    logic [DenW-1:0]     den;
    logic [NumW-1:0]     num_x;
    logic [NumW-1:0]     num_y;
    logic [DenW-1:0]     rem_x;
    logic [DenW-1:0]     rem_y;
  } tcc_word_t;

endpackage
`default_nettype wire

@@ rtl/core/tcc_front.sv @@
`default_nettype none
module tcc_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          take_i,
  input  wire  [tcc_pkg::CoordW-1:0]   ax_i,
  input  wire  [tcc_pkg::CoordW-1:0]   ay_i,
  input  wire  [tcc_pkg::CoordW-1:0]   bx_i,
  input  wire  [tcc_pkg::CoordW-1:0]   by_coord_i,
  input  wire  [tcc_pkg::CoordW-1:0]   cx_i,
  input  wire  [tcc_pkg::CoordW-1:0]   cy_i,
  input  wire  [tcc_pkg::ThrW-1:0]     thr_i,
  output logic                         live_o,
  output tcc_pkg::tcc_word_t           word_o
);
  import tcc_pkg::*;

  logic [4:0] live_q;

  // stage 1: edge vectors
  logic signed [DiffW-1:0]  abx1_q, aby1_q, acx1_q, acy1_q;
  logic [CoordW-1:0]        ax1_q, ay1_q;
  // stage 2: products
  logic signed [ProdW-1:0]  pad2_q, pbc2_q, sabx2_q, saby2_q, sacx2_q, sacy2_q;
  logic signed [DiffW-1:0]  abx2_q, aby2_q, acx2_q, acy2_q;
  logic [CoordW-1:0]        ax2_q, ay2_q;
  // stage 3: cross product and lengths
  logic signed [DW-1:0]     d3_q;
  logic [LenW-1:0]          lab3_q, lac3_q;
  logic signed [DiffW-1:0]  abx3_q, aby3_q, acx3_q, acy3_q;
  logic [CoordW-1:0]        ax3_q, ay3_q;
  // stage 4: numerator terms
  logic signed [NumW:0]     t1_q, t2_q, t3_q, t4_q;
  logic [MagW-1:0]          dmag4_q;
  logic                     dneg4_q, bad4_q;
  logic [CoordW-1:0]        ax4_q, ay4_q;

  logic signed [DW-1:0]     d_neg;
  logic [MagW-1:0]          dmag_d;
  logic signed [NumW:0]     nx_d, ny_d, nx_neg, ny_neg;
  tcc_word_t                word_d, word_q;

  always_comb begin
    d_neg  = -d3_q;
    dmag_d = d3_q[DW-1] ? d_neg[MagW-1:0] : d3_q[MagW-1:0];
    nx_d   = t1_q - t2_q;
    ny_d   = t3_q - t4_q;
    nx_neg = -nx_d;
    ny_neg = -ny_d;
    word_d.bad   = bad4_q;
    word_d.neg_x = nx_d[NumW] ^ dneg4_q;
    word_d.neg_y = ny_d[NumW] ^ dneg4_q;
    word_d.ax    = ax4_q;
    word_d.ay    = ay4_q;
    word_d.den   = {dmag4_q, 1'b0};
    word_d.num_x = nx_d[NumW] ? nx_neg[NumW-1:0] : nx_d[NumW-1:0];
    word_d.num_y = ny_d[NumW] ? ny_neg[NumW-1:0] : ny_d[NumW-1:0];
    word_d.rem_x = '0;
    word_d.rem_y = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
    end else begin
      live_q <= {live_q[3:0], take_i};
    end
  end

  always_ff @(posedge clk_i) begin
    abx1_q <= $signed({bx_i[CoordW-1], bx_i}) - $signed({ax_i[CoordW-1], ax_i});
    aby1_q <= $signed({by_coord_i[CoordW-1], by_coord_i}) - $signed({ay_i[CoordW-1], ay_i});
    acx1_q <= $signed({cx_i[CoordW-1], cx_i}) - $signed({ax_i[CoordW-1], ax_i});
    acy1_q <= $signed({cy_i[CoordW-1], cy_i}) - $signed({ay_i[CoordW-1], ay_i});
    ax1_q  <= ax_i;
    ay1_q  <= ay_i;

    pad2_q  <= abx1_q * acy1_q;
    pbc2_q  <= aby1_q * acx1_q;
    sabx2_q <= abx1_q * abx1_q;
    saby2_q <= aby1_q * aby1_q;
    sacx2_q <= acx1_q * acx1_q;
    sacy2_q <= acy1_q * acy1_q;
    abx2_q  <= abx1_q;
    aby2_q  <= aby1_q;
    acx2_q  <= acx1_q;
    acy2_q  <= acy1_q;
    ax2_q   <= ax1_q;
    ay2_q   <= ay1_q;

    d3_q   <= {pad2_q[ProdW-1], pad2_q} - {pbc2_q[ProdW-1], pbc2_q};
    lab3_q <= LenW'(sabx2_q) + LenW'(saby2_q);
    lac3_q <= LenW'(sacx2_q) + LenW'(sacy2_q);
    abx3_q <= abx2_q;
    aby3_q <= aby2_q;
    acx3_q <= acx2_q;
    acy3_q <= acy2_q;
    ax3_q  <= ax2_q;
    ay3_q  <= ay2_q;

    t1_q    <= $signed({1'b0, lab3_q}) * acy3_q;
    t2_q    <= $signed({1'b0, lac3_q}) * aby3_q;
    t3_q    <= $signed({1'b0, lac3_q}) * abx3_q;
    t4_q    <= $signed({1'b0, lab3_q}) * acx3_q;
    dmag4_q <= dmag_d;
    dneg4_q <= d3_q[DW-1];
    bad4_q  <= (dmag_d <= MagW'(thr_i));
    ax4_q   <= ax3_q;
    ay4_q   <= ay3_q;

    word_q <= word_d;
  end

  assign live_o = live_q[4];
  assign word_o = word_q;

endmodule
`default_nettype wire

@@ rtl/core/tcc_div_cell.sv @@
`default_nettype none
module tcc_div_cell (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  live_i,
  input  tcc_pkg::tcc_word_t   word_i,
  output logic                 live_o,
  output tcc_pkg::tcc_word_t   word_o
);
  import tcc_pkg::*;

  logic [DenW:0]  r2x, r2y, dx, dy;
  logic           gex, gey;
  tcc_word_t      word_d, word_q;
  logic           live_q;

  // one restoring step per axis, quotient bit shifts in at the bottom
  always_comb begin
    r2x = {word_i.rem_x, word_i.num_x[NumW-1]};
    r2y = {word_i.rem_y, word_i.num_y[NumW-1]};
    gex = r2x >= {1'b0, word_i.den};
    gey = r2y >= {1'b0, word_i.den};
    dx  = r2x - {1'b0, word_i.den};
    dy  = r2y - {1'b0, word_i.den};
    word_d       = word_i;
    word_d.rem_x = gex ? dx[DenW-1:0] : r2x[DenW-1:0];
    word_d.rem_y = gey ? dy[DenW-1:0] : r2y[DenW-1:0];
    word_d.num_x = {word_i.num_x[NumW-2:0], gex};
    word_d.num_y = {word_i.num_y[NumW-2:0], gey};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else begin
      live_q <= live_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign live_o = live_q;
  assign word_o = word_q;

endmodule
`default_nettype wire

@@ rtl/core/triangle_circumcenter.sv @@
// channel   | direction | handshake          | word
// ----------+-----------+--------------------+-----------------------------------------
// vertices  | in        | start, busy        | ax_i ay_i bx_i by_coord_i cx_i cy_i
// threshold | in        | threshold_we_i     | threshold_i
// center    | out       | done_o             | center_x_o center_y_o center_valid_o
//           |           |                    | saturated_o
// start to done passes 5 setup stages, one divider cell
// per numerator bit (51), one output stage; one triangle per cycle, busy stays low
// reset clears the pipeline valid flags and the threshold; no clearing pass
// the receiver cannot stall, each word shows on the outputs for one cycle
`default_nettype none
module triangle_circumcenter (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  wire  [tcc_pkg::CoordW-1:0]   ax_i,
  input  wire  [tcc_pkg::CoordW-1:0]   ay_i,
  input  wire  [tcc_pkg::CoordW-1:0]   bx_i,
  input  wire  [tcc_pkg::CoordW-1:0]   by_coord_i,
  input  wire  [tcc_pkg::CoordW-1:0]   cx_i,
  input  wire  [tcc_pkg::CoordW-1:0]   cy_i,
  input  wire                          threshold_we_i,
  input  wire  [tcc_pkg::ThrW-1:0]     threshold_i,
  output logic                         done_o,
  output logic [tcc_pkg::OutW-1:0]     center_x_o,
  output logic [tcc_pkg::OutW-1:0]     center_y_o,
  output logic                         center_valid_o,
  output logic                         saturated_o
);
  import tcc_pkg::*;

  logic [ThrW-1:0]  thr_q;
  logic             live [NumW+1];
  tcc_word_t        word [NumW+1];

  logic             done_q, valid_q, sat_q;
  logic [OutW-1:0]  cx_q, cy_q;
  logic [OutW-1:0]  ox, oy;
  logic             sx, sy;

  function automatic logic [OutW:0] axis_out(input logic [CoordW-1:0] a,
                                             input logic [NumW-1:0] q,
                                             input logic neg);
    logic signed [SumW-1:0] ae, qe, s;
    logic                   hi;
    ae = SumW'($signed(a));
    qe = $signed({2'b00, q[SatBit-1:0]});
    s  = neg ? ae - qe : ae + qe;
    hi = |q[NumW-1:SatBit];
    if (hi) begin
      axis_out = neg ? {1'b1, 1'b1, {(OutW-1){1'b0}}} : {1'b1, 1'b0, {(OutW-1){1'b1}}};
    end else if (s > SumW'(32'sh7fffffff)) begin
      axis_out = {1'b1, 1'b0, {(OutW-1){1'b1}}};
    end else if (s < -SumW'(33'sh080000000)) begin
      axis_out = {1'b1, 1'b1, {(OutW-1){1'b0}}};
    end else begin
      axis_out = {1'b0, s[OutW-1:0]};
    end
  endfunction

  assign busy = 1'b0;

  tcc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (start && !busy),
    .ax_i       (ax_i),
    .ay_i       (ay_i),
    .bx_i       (bx_i),
    .by_coord_i (by_coord_i),
    .cx_i       (cx_i),
    .cy_i       (cy_i),
    .thr_i      (thr_q),
    .live_o     (live[0]),
    .word_o     (word[0])
  );

  for (genvar g = 0; g < NumW; g++) begin : g_cell
    tcc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .live_i (live[g]),
      .word_i (word[g]),
      .live_o (live[g+1]),
      .word_o (word[g+1])
    );
  end

  always_comb begin
    {sx, ox} = axis_out(word[NumW].ax, word[NumW].num_x, word[NumW].neg_x);
    {sy, oy} = axis_out(word[NumW].ay, word[NumW].num_y, word[NumW].neg_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= '0;
      done_q <= 1'b0;
    end else begin
      if (threshold_we_i) begin
        thr_q <= threshold_i;
      end
      done_q <= live[NumW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (word[NumW].bad) begin
      cx_q    <= '0;
      cy_q    <= '0;
      valid_q <= 1'b0;
      sat_q   <= 1'b0;
    end else begin
      cx_q    <= ox;
      cy_q    <= oy;
      valid_q <= 1'b1;
      sat_q   <= sx | sy;
    end
  end

  assign done_o         = done_q;
  assign center_x_o     = cx_q;
  assign center_y_o     = cy_q;
  assign center_valid_o = valid_q;
  assign saturated_o    = sat_q;

endmodule
`default_nettype wire

@@ rtl/core/tcc_checker.sv @@
`default_nettype none
`include "triangle_circumcenter_macros.svh"
module tcc_props (
  input wire                         clk_i,
  input wire                         rst_ni,
  input wire                         busy,
  input wire                         done_o,
  input wire [tcc_pkg::OutW-1:0]     center_x_o,
  input wire [tcc_pkg::OutW-1:0]     center_y_o,
  input wire                         center_valid_o,
  input wire                         saturated_o
);
  import tcc_pkg::*;

  logic x_edge, y_edge;

  assign x_edge = (center_x_o == {1'b0, {(OutW-1){1'b1}}}) ||
                  (center_x_o == {1'b1, {(OutW-1){1'b0}}});
  assign y_edge = (center_y_o == {1'b0, {(OutW-1){1'b1}}}) ||
                  (center_y_o == {1'b1, {(OutW-1){1'b0}}});

  // degenerate word (|det| at or below threshold) carries zeros and no clip flag
  `TCC_ASSERT_IMP(a_degen_zero, clk_i, rst_ni, done_o && !center_valid_o,
                  center_x_o == '0 && center_y_o == '0 && !saturated_o)
  // clip flag needs a coordinate at a limit
  `TCC_ASSERT_IMP(a_sat_limit, clk_i, rst_ni, done_o && saturated_o,
                  x_edge || y_edge)
  // fully pipelined, never refuses a start
  `TCC_ASSERT(a_never_busy, clk_i, rst_ni, !busy)

endmodule

bind triangle_circumcenter tcc_props u_tcc_props (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .busy           (busy),
  .done_o         (done_o),
  .center_x_o     (center_x_o),
  .center_y_o     (center_y_o),
  .center_valid_o (center_valid_o),
  .saturated_o    (saturated_o)
);
`default_nettype wire
